@@ hw/rtl/cln_pkg.sv @@
// shared types, constants and command codes for the circular list block
package cln_pkg;

    localparam int unsigned ID_BITS = 10;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_INS_AFTER  = 3'd1;
    localparam logic [2:0] CMD_INS_BEFORE = 3'd2;
    localparam logic [2:0] CMD_REM_NEXT   = 3'd3;
    localparam logic [2:0] CMD_REM_PREV   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ANCHOR = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;

    localparam logic [ID_BITS-1:0] ID_ZERO = '0;
    localparam logic [ID_BITS-1:0] ID_ONE  = {{(ID_BITS-1){1'b0}}, 1'b1};
    localparam logic [ID_BITS-1:0] ID_LAST = '1;
    localparam logic [ID_BITS:0]   SIZE_ZERO = '0;
    localparam logic [ID_BITS:0]   SIZE_ONE  = {{ID_BITS{1'b0}}, 1'b1};

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [ID_BITS:0]   size_t;

    typedef struct packed {
        logic present;
        id_t  link;
    } prev_entry_t;

    typedef struct packed {
        logic en;
        id_t  addr;
        id_t  data;
    } next_wr_t;

    typedef struct packed {
        logic        en;
        id_t         addr;
        prev_entry_t data;
    } prev_wr_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD2,
        S_EXEC,
        S_WR2
    } state_t;

endpackage

@@ hw/rtl/circular_list_neighbor_edit.sv @@
// top level: ring of distinct ids with neighbour edits, two link memories
// After reset the block sweeps the membership bits of all 1024 ids, one id
// per cycle, with busy high. A command word is taken when start is high and
// busy is low. From the accepting cycle to the next possible accept an edit
// goes through these steps: the anchor entry is read, then the neighbour or
// new id entry, then the evaluation with the first pair of writes, then the
// second pair of writes; both link memories have one read and one write port,
// so the three or four table writes of an edit are split between the
// evaluation and the second write step. Errors, duplicates, appends to an
// empty ring and removal of the last id skip the second write. The result
// appears on neighbor_id and status for exactly one cycle with result_valid
// high, the cycle after the evaluation; it is not held, so the receiver must
// take it then. Append and unused command codes give no result.
module circular_list_neighbor_edit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          cmd,
    input  cln_pkg::id_t        anchor_id,
    input  cln_pkg::id_t        new_id,
    output logic                result_valid,
    output cln_pkg::id_t        neighbor_id,
    output logic [1:0]          status
);

    import cln_pkg::*;

    id_t         mem_raddr;
    id_t         next_rdata;
    prev_entry_t prev_rdata;
    next_wr_t    next_wr;
    prev_wr_t    prev_wr;

    cln_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .anchor_id    (anchor_id),
        .new_id       (new_id),
        .result_valid (result_valid),
        .neighbor_id  (neighbor_id),
        .status       (status),
        .mem_raddr    (mem_raddr),
        .next_rdata   (next_rdata),
        .prev_rdata   (prev_rdata),
        .next_wr      (next_wr),
        .prev_wr      (prev_wr)
    );

    // successor links
    cln_ram #(
        .WIDTH     (ID_BITS),
        .ADDR_BITS (ID_BITS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_wr.en),
        .waddr (next_wr.addr),
        .wdata (next_wr.data),
        .raddr (mem_raddr),
        .rdata (next_rdata)
    );

    // membership bit with predecessor link
    cln_ram #(
        .WIDTH     ($bits(prev_entry_t)),
        .ADDR_BITS (ID_BITS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_wr.en),
        .waddr (prev_wr.addr),
        .wdata (prev_wr.data),
        .raddr (mem_raddr),
        .rdata (prev_rdata)
    );

endmodule

@@ hw/rtl/cln_ram.sv @@
// generic single write port ram with registered read
module cln_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/cln_ctrl.sv @@
// command sequencer: reads link tables, evaluates the edit and writes back
module cln_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           cmd,
    input  cln_pkg::id_t         anchor_id,
    input  cln_pkg::id_t         new_id,
    output logic                 result_valid,
    output cln_pkg::id_t         neighbor_id,
    output logic [1:0]           status,
    output cln_pkg::id_t         mem_raddr,
    input  cln_pkg::id_t         next_rdata,
    input  cln_pkg::prev_entry_t prev_rdata,
    output cln_pkg::next_wr_t    next_wr,
    output cln_pkg::prev_wr_t    prev_wr
);

    import cln_pkg::*;

    state_t      state_reg, state_next;
    id_t         clr_cnt_reg, clr_cnt_next;
    id_t         head_reg, head_next;
    size_t       size_reg, size_next;
    logic        res_valid_reg, res_valid_next;

    logic [2:0]  cmd_reg, cmd_next;
    id_t         anchor_reg, anchor_next;
    id_t         nid_reg, nid_next;
    logic        pres1_reg, pres1_next;
    id_t         prev1_reg, prev1_next;
    id_t         nb_reg, nb_next;
    id_t         res_nb_reg, res_nb_next;
    logic [1:0]  res_status_reg, res_status_next;
    next_wr_t    wr2_next_reg, wr2_next_next;
    prev_wr_t    wr2_prev_reg, wr2_prev_next;

    logic        is_app, is_ins, is_rem, report;
    logic        app_first, do_link, do_unlink, unlink_last;
    id_t         link_a, link_b, nb_sel;

    // decode of the latched word and the second read
    always_comb
    begin
        is_app = (cmd_reg == CMD_APPEND);
        is_ins = (cmd_reg == CMD_INS_AFTER) || (cmd_reg == CMD_INS_BEFORE);
        is_rem = (cmd_reg == CMD_REM_NEXT) || (cmd_reg == CMD_REM_PREV);
        report = is_ins || is_rem;
        app_first = is_app && !prev_rdata.present && (size_reg == SIZE_ZERO);
        do_link = (is_app && !prev_rdata.present && (size_reg != SIZE_ZERO))
            || (is_ins && pres1_reg && !prev_rdata.present);
        do_unlink = is_rem && pres1_reg;
        unlink_last = do_unlink && (size_reg == SIZE_ONE);
        nb_sel = ((cmd_reg == CMD_INS_AFTER) || (cmd_reg == CMD_REM_NEXT))
            ? next_rdata : prev_rdata.link;
        case (cmd_reg)
            CMD_APPEND:
            begin
                link_a = prev1_reg;
                link_b = head_reg;
            end
            CMD_INS_AFTER:
            begin
                link_a = anchor_reg;
                link_b = nb_reg;
            end
            default:
            begin
                link_a = nb_reg;
                link_b = anchor_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ID_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (do_link || (do_unlink && !unlink_last))
                begin
                    state_next = S_WR2;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WR2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        size_next       = size_reg;
        res_valid_next  = 1'b0;
        cmd_next        = cmd_reg;
        anchor_next     = anchor_reg;
        nid_next        = nid_reg;
        pres1_next      = pres1_reg;
        prev1_next      = prev1_reg;
        nb_next         = nb_reg;
        res_nb_next     = res_nb_reg;
        res_status_next = res_status_reg;
        wr2_next_next   = wr2_next_reg;
        wr2_prev_next   = wr2_prev_reg;
        mem_raddr       = nid_reg;
        next_wr         = '0;
        prev_wr         = '0;
        case (state_reg)
            S_CLEAR:
            begin
                prev_wr.en   = 1'b1;
                prev_wr.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ID_ONE;
            end
            S_IDLE:
            begin
                mem_raddr = (cmd == CMD_APPEND) ? head_reg : anchor_id;
                if (start)
                begin
                    cmd_next    = cmd;
                    anchor_next = anchor_id;
                    nid_next    = new_id;
                end
            end
            S_RD2:
            begin
                pres1_next = prev_rdata.present;
                prev1_next = prev_rdata.link;
                nb_next    = nb_sel;
                mem_raddr  = is_rem ? nb_sel : nid_reg;
            end
            S_EXEC:
            begin
                res_valid_next = report;
                if (!pres1_reg)
                begin
                    res_status_next = ST_NO_ANCHOR;
                    res_nb_next     = ID_ZERO;
                end
                else if (is_ins && prev_rdata.present)
                begin
                    res_status_next = ST_DUPLICATE;
                    res_nb_next     = ID_ZERO;
                end
                else
                begin
                    res_status_next = ST_OK;
                    res_nb_next     = nb_reg;
                end
                if (app_first)
                begin
                    next_wr.en   = 1'b1;
                    next_wr.addr = nid_reg;
                    next_wr.data = nid_reg;
                    prev_wr.en   = 1'b1;
                    prev_wr.addr = nid_reg;
                    prev_wr.data = '{present: 1'b1, link: nid_reg};
                    head_next    = nid_reg;
                    size_next    = SIZE_ONE;
                end
                if (do_link)
                begin
                    next_wr.en    = 1'b1;
                    next_wr.addr  = link_a;
                    next_wr.data  = nid_reg;
                    prev_wr.en    = 1'b1;
                    prev_wr.addr  = nid_reg;
                    prev_wr.data  = '{present: 1'b1, link: link_a};
                    wr2_next_next = '{en: 1'b1, addr: nid_reg, data: link_b};
                    wr2_prev_next = '{en: 1'b1, addr: link_b,
                                      data: '{present: 1'b1, link: nid_reg}};
                    size_next     = size_reg + SIZE_ONE;
                    if (((cmd_reg == CMD_INS_AFTER) && (link_b == head_reg))
                        || ((cmd_reg == CMD_INS_BEFORE) && (anchor_reg == head_reg)))
                    begin
                        head_next = nid_reg;
                    end
                end
                if (do_unlink)
                begin
                    prev_wr.en    = 1'b1;
                    prev_wr.addr  = nb_reg;
                    prev_wr.data  = '0;
                    size_next     = size_reg - SIZE_ONE;
                    wr2_next_next = '{en: 1'b1, addr: prev_rdata.link, data: next_rdata};
                    wr2_prev_next = '{en: 1'b1, addr: next_rdata,
                                      data: '{present: 1'b1, link: prev_rdata.link}};
                    if (unlink_last)
                    begin
                        head_next = ID_ZERO;
                    end
                    else if (nb_reg == head_reg)
                    begin
                        head_next = next_rdata;
                    end
                end
            end
            S_WR2:
            begin
                next_wr = wr2_next_reg;
                prev_wr = wr2_prev_reg;
            end
            default:
            begin
                mem_raddr = nid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= ID_ZERO;
            head_reg      <= ID_ZERO;
            size_reg      <= SIZE_ZERO;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            head_reg      <= head_next;
            size_reg      <= size_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        anchor_reg     <= anchor_next;
        nid_reg        <= nid_next;
        pres1_reg      <= pres1_next;
        prev1_reg      <= prev1_next;
        nb_reg         <= nb_next;
        res_nb_reg     <= res_nb_next;
        res_status_reg <= res_status_next;
        wr2_next_reg   <= wr2_next_next;
        wr2_prev_reg   <= wr2_prev_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign neighbor_id  = res_nb_reg;
    assign status       = res_status_reg;

endmodule
